>>> rtl/core/gimbal_stillness_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gimbal stillness detector
// Short forms for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef GIMBAL_STILLNESS_DETECTOR_ASSERT_SVH
`define GIMBAL_STILLNESS_DETECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSD_ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("gimbal stillness detector: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GSD_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("gimbal stillness detector: next-cycle check failed");

`endif

>>> rtl/core/gsd_pkg.sv
// ----------------------------------------------------------------------------
// gsd_pkg
// Types and constants shared by the gimbal stillness detector modules.
// ----------------------------------------------------------------------------
package gsd_pkg;

    localparam int ANGLE_W     = 32;
    localparam int DIST_W      = 32;
    localparam int THR_W       = 31;
    localparam int COUNT_W     = 16;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 2;
    localparam int WINDOW_DEF  = 16;

    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(655);
    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(400);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_AZ_THR      = 2'd0,
        CFG_EL_THR      = 2'd1,
        CFG_STILL_LIMIT = 2'd2
    } cfg_index_t;

    // One azimuth/elevation pair.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] el;
        logic signed [ANGLE_W-1:0] az;
    } sample_t;

    // Stability thresholds, broadcast to every cell.
    typedef struct packed {
        logic [THR_W-1:0] el_thr;
        logic [THR_W-1:0] az_thr;
    } thr_t;

    // Per-request control for the cell row.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

>>> rtl/core/gsd_cell.sv
// ----------------------------------------------------------------------------
// gsd_cell
// One stored sample of the sliding window with its own deviation check.
// ----------------------------------------------------------------------------
module gsd_cell
    import gsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  thr_t       thr,
    input  sample_t    cur,
    input  logic       in_valid,
    input  sample_t    in_data,
    output logic       valid,
    output sample_t    data,
    output logic       ok
);

    logic    valid_reg;
    sample_t data_reg;

    // True when |a - b| <= thr, with the difference taken at 33 bits.
    function automatic logic within_thr(
        input logic signed [ANGLE_W-1:0] a,
        input logic signed [ANGLE_W-1:0] b,
        input logic [THR_W-1:0]          t
    );
        logic signed [ANGLE_W:0] d;
        logic signed [ANGLE_W:0] lim;
        begin
            d   = $signed({a[ANGLE_W-1], a}) - $signed({b[ANGLE_W-1], b});
            lim = $signed({{(ANGLE_W+1-THR_W){1'b0}}, t});
            return (d <= lim) && (d >= -lim);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= in_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign ok    = !valid_reg ||
                   (within_thr(data_reg.az, cur.az, thr.az_thr) &&
                    within_thr(data_reg.el, cur.el, thr.el_thr));

endmodule

>>> rtl/core/gsd_window.sv
// ----------------------------------------------------------------------------
// gsd_window
// Row of window cells; on each accepted non-reference request the new sample
// enters at the head and every older sample moves one cell along.
// ----------------------------------------------------------------------------
module gsd_window
    import gsd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  thr_t       thr,
    input  sample_t    cur,
    output logic       all_ok
);

    generate
        if (WINDOW > 1)
        begin : g_row
            // The newest sample always matches itself, so only the WINDOW-1
            // older ones need a cell.
            localparam int CELLS = WINDOW - 1;

            logic    chain_valid [CELLS+1];
            sample_t chain_data  [CELLS+1];
            logic [CELLS-1:0] cell_ok;

            assign chain_valid[0] = 1'b1;
            assign chain_data[0]  = cur;

            for (genvar k = 0; k < CELLS; k++)
            begin : g_cell
                gsd_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (ctrl),
                    .thr      (thr),
                    .cur      (cur),
                    .in_valid (chain_valid[k]),
                    .in_data  (chain_data[k]),
                    .valid    (chain_valid[k+1]),
                    .data     (chain_data[k+1]),
                    .ok       (cell_ok[k])
                );
            end

            assign all_ok = &cell_ok;
        end
        else
        begin : g_single
            assign all_ok = 1'b1;
        end
    endgenerate

endmodule

>>> rtl/core/gimbal_stillness_detector.sv
// ----------------------------------------------------------------------------
// gimbal_stillness_detector
// Tracker sample stillness detector with held distance and image slopes.
// ----------------------------------------------------------------------------
// Each request carries one tracker sample and produces exactly one result
// request. A request is taken whenever the result register is empty or its
// contents are being taken in the same cycle, so the block sustains one
// request per clock while the receiver keeps m_tready high; the result is
// registered and appears on the output in the cycle after acceptance. In the
// row of window cells, each cell holds one of the last WINDOW-1 samples and
// compares it with the incoming sample in parallel, and the row shifts by one
// cell per accepted request. Reference-mode samples clear the stable count and
// empty the window. Configuration writes on the cfg port take effect at once
// and should be made only while no request is in flight.
// ----------------------------------------------------------------------------
`include "gimbal_stillness_detector_assert.svh"

module gimbal_stillness_detector
    import gsd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // Sample stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata, low to high: az_in[31:0], el_in[63:32], distance[95:64],
    // distance_cmd[127:96], jog_beat[159:128]
    input  logic [159:0]           s_tdata,
    // s_tuser, low to high: is_locked[0], ref_flag[1], img_taken[2]
    input  logic [2:0]             s_tuser,

    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata, low to high: stable_count[15:0], held_distance[47:16],
    // image_az[79:48], image_el[111:80], az_slope[143:112], el_slope[175:144]
    output logic [175:0]           m_tdata,
    // m_tuser, low to high: is_still[0]
    output logic [0:0]             m_tuser
);

    // ------------------------------------------------------------------
    // Request fields
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] az_in;
    logic signed [ANGLE_W-1:0] el_in;
    logic [DIST_W-1:0]         distance;
    logic [DIST_W-1:0]         distance_cmd;
    logic [31:0]               jog_beat;
    logic                      is_locked;
    logic                      ref_flag;
    logic                      img_taken;

    assign az_in        = s_tdata[31:0];
    assign el_in        = s_tdata[63:32];
    assign distance     = s_tdata[95:64];
    assign distance_cmd = s_tdata[127:96];
    assign jog_beat     = s_tdata[159:128];
    assign is_locked    = s_tuser[0];
    assign ref_flag     = s_tuser[1];
    assign img_taken    = s_tuser[2];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THR_W-1:0]   az_thr_reg;
    logic [THR_W-1:0]   el_thr_reg;
    logic [COUNT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_thr_reg <= THR_RESET;
            el_thr_reg <= THR_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_AZ_THR:      az_thr_reg <= cfg_data[THR_W-1:0];
                CFG_EL_THR:      el_thr_reg <= cfg_data[THR_W-1:0];
                CFG_STILL_LIMIT: limit_reg  <= cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the result register doubles as the state, so a new request
    // is taken as soon as the current result is gone or leaving.
    // ------------------------------------------------------------------
    logic accept;
    logic out_valid_reg;
    logic out_valid_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Sliding window of cells
    // ------------------------------------------------------------------
    cell_ctrl_t win_ctrl;
    thr_t       win_thr;
    sample_t    cur_sample;
    logic       win_ok;

    assign win_ctrl.shift  = accept && !ref_flag;
    assign win_ctrl.clear  = accept && ref_flag;
    assign win_thr.az_thr  = az_thr_reg;
    assign win_thr.el_thr  = el_thr_reg;
    assign cur_sample.az   = az_in;
    assign cur_sample.el   = el_in;

    gsd_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (win_ctrl),
        .thr    (win_thr),
        .cur    (cur_sample),
        .all_ok (win_ok)
    );

    // ------------------------------------------------------------------
    // Tracker state
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]        count_reg,   count_next;
    logic                      still_reg,   still_next;
    logic [DIST_W-1:0]         hold_reg,    hold_next;
    logic [31:0]               beat_reg,    beat_next;
    sample_t                   prev_reg,    prev_next;
    sample_t                   image_reg,   image_next;
    sample_t                   older_reg,   older_next;
    sample_t                   slope_reg,   slope_next;
    logic [COUNT_W-1:0]        count_base;

    always_comb
    begin
        count_next = count_reg;
        hold_next  = hold_reg;
        beat_next  = beat_reg;
        prev_next  = prev_reg;
        image_next = image_reg;
        older_next = older_reg;
        slope_next = slope_reg;
        // A locked sample restarts the count before the window check, so a
        // stable locked sample leaves the count at one.
        count_base = is_locked ? '0 : count_reg;

        if (accept)
        begin
            if (ref_flag)
            begin
                count_next = '0;
            end
            else
            begin
                if (is_locked)
                begin
                    hold_next = distance;
                end
                else if (jog_beat != beat_reg)
                begin
                    beat_next = jog_beat;
                    hold_next = distance_cmd;
                end

                if (!win_ok)
                begin
                    count_next = '0;
                end
                else if (count_base != COUNT_MAX)
                begin
                    count_next = count_base + COUNT_W'(1);
                end
                else
                begin
                    count_next = count_base;
                end
            end

            // The image history takes the sample before this one, whether
            // or not the window was updated.
            if (img_taken)
            begin
                older_next    = image_reg;
                image_next    = prev_reg;
                slope_next.az = prev_reg.az - image_reg.az;
                slope_next.el = prev_reg.el - image_reg.el;
            end
            prev_next = cur_sample;
        end

        still_next = accept ? (count_next > limit_reg) : still_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            still_reg <= 1'b0;
            hold_reg  <= '0;
            beat_reg  <= '0;
            prev_reg  <= '0;
            image_reg <= '0;
            older_reg <= '0;
            slope_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            still_reg <= still_next;
            hold_reg  <= hold_next;
            beat_reg  <= beat_next;
            prev_reg  <= prev_next;
            image_reg <= image_next;
            older_reg <= older_next;
            slope_reg <= slope_next;
        end
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {slope_reg.el, slope_reg.az, image_reg.el, image_reg.az,
                       hold_reg, count_reg};
    assign m_tuser  = still_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `GSD_ASSERT_NEXT(a_ref_clears_count, clk, rst_n, win_ctrl.clear, count_reg == '0)
    `GSD_ASSERT_NEXT(a_lock_dist, clk, rst_n, win_ctrl.shift && is_locked, hold_reg == $past(distance))
    `GSD_ASSERT_NEXT(a_slope_az, clk, rst_n, accept && img_taken, slope_reg.az == image_reg.az - older_reg.az)
    `GSD_ASSERT_SAME(a_still_matches, clk, rst_n, out_valid_reg, still_reg == (count_reg > limit_reg))
    `GSD_ASSERT_NEXT(a_older_is_old_image, clk, rst_n, accept && img_taken, older_reg == $past(image_reg))

endmodule

>>> sim/tb_gimbal_stillness_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the gimbal stillness detector
// Streams tracker samples into the block with random gaps on both sides,
// predicts every result request in step with the accepted samples, and
// compares each result field by field against that prediction.
// ----------------------------------------------------------------------------
module tb_gimbal_stillness_detector;
    import gsd_pkg::*;

    localparam int WINDOW      = WINDOW_DEF;
    // Cycles in a row with no handshake on either stream before the run is
    // abandoned. The longest legal quiet spell is a sender gap plus a receiver
    // stall, or a drain before a register write.
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 380;

    // One tracker sample as it travels on the sample stream.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] az;
        logic signed [ANGLE_W-1:0] el;
        logic [DIST_W-1:0]         meas;
        logic [DIST_W-1:0]         dcmd;
        logic [31:0]               beat;
        logic                      locked;
        logic                      refm;
        logic                      img;
    } tracker_sample_t;

    // One result request, unpacked from m_tdata and m_tuser.
    typedef struct packed {
        logic [COUNT_W-1:0]        count;
        logic                      still;
        logic [DIST_W-1:0]         hold;
        logic signed [ANGLE_W-1:0] img_az;
        logic signed [ANGLE_W-1:0] img_el;
        logic signed [ANGLE_W-1:0] az_slope;
        logic signed [ANGLE_W-1:0] el_slope;
    } tracker_report_t;

    // A row of the directed plan: a sample and, where it is obvious, the
    // result typed in by hand.
    typedef struct packed {
        tracker_sample_t smp;
        logic            has_lit;
        tracker_report_t lit;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_AZ_THR;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata, low to high: az_in, el_in, distance, distance_cmd, jog_beat
    logic [159:0]           s_tdata = '0;
    // s_tuser, low to high: is_locked, ref_flag, img_taken
    logic [2:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata, low to high: stable_count, held_distance, image_az, image_el,
    // az_slope, el_slope
    logic [175:0]           m_tdata;
    // m_tuser, low to high: is_still
    logic [0:0]             m_tuser;

    gimbal_stillness_detector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow of the block's state, advanced once per accepted sample request.
    // ------------------------------------------------------------------------
    logic [THR_W-1:0]          thr_az;
    logic [THR_W-1:0]          thr_el;
    logic [COUNT_W-1:0]        still_lim;
    logic signed [ANGLE_W-1:0] win_az [WINDOW];
    logic signed [ANGLE_W-1:0] win_el [WINDOW];
    int                        win_head;
    int                        win_fill;
    logic [COUNT_W-1:0]        stable_cnt;
    logic [DIST_W-1:0]         dist_hold;
    logic [31:0]               beat_seen;
    logic signed [ANGLE_W-1:0] prev_az, prev_el;
    logic signed [ANGLE_W-1:0] img_az, img_el;
    logic signed [ANGLE_W-1:0] old_az, old_el;
    logic signed [ANGLE_W-1:0] slope_az, slope_el;

    tracker_report_t due_reports [$];

    // Sample currently offered on the stream, with its hand-typed result.
    tracker_sample_t cur_sample;
    logic            cur_has_lit = 1'b0;
    tracker_report_t cur_lit;

    // When set, neither side idles.
    logic calm = 1'b0;

    int mismatches   = 0;
    int n_samples    = 0;
    int n_results    = 0;
    int n_images     = 0;
    int n_refmode    = 0;
    int n_still      = 0;
    int n_saturated  = 0;
    int peak_count   = 0;
    int idle_cycles  = 0;

    // Random generator state: a run of samples jitters around one base point.
    int          run_left = 0;
    logic [31:0] base_az, base_el, jit_az, jit_el;
    logic [31:0] beat_now = '0;

    task automatic clear_tracker();
        thr_az     = THR_RESET;
        thr_el     = THR_RESET;
        still_lim  = LIMIT_RESET;
        win_head   = 0;
        win_fill   = 0;
        stable_cnt = '0;
        dist_hold  = '0;
        beat_seen  = '0;
        prev_az    = '0;
        prev_el    = '0;
        img_az     = '0;
        img_el     = '0;
        old_az     = '0;
        old_el     = '0;
        slope_az   = '0;
        slope_el   = '0;
    endtask

    // Applies one sample to the shadow state and returns the result the
    // block should send for it.
    function automatic tracker_report_t advance_tracker(tracker_sample_t s);
        tracker_report_t r;
        longint          worst_az;
        longint          worst_el;
        longint          d;
        int              i;
        worst_az = 0;
        worst_el = 0;
        if (!s.refm)
        begin
            // Lock takes precedence over a heartbeat change, and clears the
            // count before the window check.
            if (s.locked)
            begin
                dist_hold  = s.meas;
                stable_cnt = '0;
            end
            else if (s.beat != beat_seen)
            begin
                beat_seen = s.beat;
                dist_hold = s.dcmd;
            end
            win_az[win_head] = s.az;
            win_el[win_head] = s.el;
            win_head = (win_head + 1) % WINDOW;
            if (win_fill < WINDOW)
                win_fill++;
            // Differences are taken wide so that opposite extremes never wrap.
            for (i = 0; i < win_fill; i++)
            begin
                d = longint'(win_az[i]) - longint'(s.az);
                if (d < 0)
                    d = -d;
                if (d > worst_az)
                    worst_az = d;
                d = longint'(win_el[i]) - longint'(s.el);
                if (d < 0)
                    d = -d;
                if (d > worst_el)
                    worst_el = d;
            end
            if (worst_az <= longint'(thr_az) && worst_el <= longint'(thr_el))
            begin
                if (stable_cnt != COUNT_MAX)
                    stable_cnt++;
            end
            else
                stable_cnt = '0;
        end
        else
        begin
            stable_cnt = '0;
            win_fill   = 0;
            win_head   = 0;
        end
        // The image history moves even for reference-mode samples.
        if (s.img)
        begin
            old_az   = img_az;
            old_el   = img_el;
            img_az   = prev_az;
            img_el   = prev_el;
            slope_az = img_az - old_az;
            slope_el = img_el - old_el;
        end
        prev_az = s.az;
        prev_el = s.el;

        r.count    = stable_cnt;
        r.still    = (stable_cnt > still_lim);
        r.hold     = dist_hold;
        r.img_az   = img_az;
        r.img_el   = img_el;
        r.az_slope = slope_az;
        r.el_slope = slope_el;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t on result %0d: %s got %h, wanted %h",
                 $realtime, n_results, field, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: records accepted sample requests and checks result requests.
    // Everything is sampled at the rising edge, before the block updates.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        tracker_report_t got;
        tracker_report_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = advance_tracker(cur_sample);
                if (cur_has_lit)
                    want = cur_lit;
                due_reports.insert(due_reports.size(), want);
                n_samples++;
                if (cur_sample.img)
                    n_images++;
                if (cur_sample.refm)
                    n_refmode++;
            end
            if (m_tvalid && m_tready)
            begin
                got.count    = m_tdata[15:0];
                got.hold     = m_tdata[47:16];
                got.img_az   = m_tdata[79:48];
                got.img_el   = m_tdata[111:80];
                got.az_slope = m_tdata[143:112];
                got.el_slope = m_tdata[175:144];
                got.still    = m_tuser[0];
                if (due_reports.size() == 0)
                    report_mismatch("unexpected result", 32'(got.count), '0);
                else
                begin
                    want = due_reports.pop_front();
                    if (got.count !== want.count)
                        report_mismatch("stable_count", 32'(got.count), 32'(want.count));
                    if (got.still !== want.still)
                        report_mismatch("is_still", 32'(got.still), 32'(want.still));
                    if (got.hold !== want.hold)
                        report_mismatch("held_distance", got.hold, want.hold);
                    if (got.img_az !== want.img_az)
                        report_mismatch("image_az", got.img_az, want.img_az);
                    if (got.img_el !== want.img_el)
                        report_mismatch("image_el", got.img_el, want.img_el);
                    if (got.az_slope !== want.az_slope)
                        report_mismatch("az_slope", got.az_slope, want.az_slope);
                    if (got.el_slope !== want.el_slope)
                        report_mismatch("el_slope", got.el_slope, want.el_slope);
                end
                n_results++;
                if (got.still === 1'b1)
                    n_still++;
                if (got.count === COUNT_MAX)
                    n_saturated++;
                if (int'(got.count) > peak_count)
                    peak_count = int'(got.count);
            end
            // Watchdog: the run is abandoned if neither stream moves for long.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: drops m_tready for random spells, changing only at falling
    // edges.
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (calm)
            begin
                m_tready = 1'b1;
                @(negedge clk);
            end
            else
            begin
                n = idle_len();
                if (n != 0)
                begin
                    m_tready = 1'b0;
                    repeat (n) @(negedge clk);
                end
                m_tready = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    end

    // Offers one sample request and returns at the falling edge after it has
    // been accepted. tvalid stays high into the next request unless a gap is
    // drawn.
    task automatic offer_sample(tracker_sample_t s, logic has_lit, tracker_report_t lit);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_sample  = s;
        cur_has_lit = has_lit;
        cur_lit     = lit;
        s_tdata     = {s.beat, s.dcmd, s.meas, s.el, s.az};
        s_tuser     = {s.img, s.refm, s.locked};
        s_tvalid    = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Stops sending and waits until every predicted result has arrived, then
    // lets the pipeline settle. Entered and left at a falling edge.
    task automatic drain_reports();
        s_tvalid = 1'b0;
        while (due_reports.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Register write, only ever issued while the block is idle.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            CFG_AZ_THR:      thr_az    = val[THR_W-1:0];
            CFG_EL_THR:      thr_el    = val[THR_W-1:0];
            CFG_STILL_LIMIT: still_lim = val[COUNT_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] wobble(logic [31:0] base, logic [31:0] j);
        longint span;
        span = 2 * longint'(j) + 1;
        return base + 32'(longint'($urandom) % span) - j;
    endfunction

    function automatic logic [31:0] pick_jitter(logic [THR_W-1:0] thr);
        logic [31:0] j;
        // Usually tight enough to stay stable; sometimes wider than the
        // threshold so that runs break up.
        if ($urandom_range(0, 5) == 0)
            j = 32'(thr) + 32'(thr >> 1) + 32'($urandom_range(1, 4));
        else
            j = 32'(thr) >> $urandom_range(1, 4);
        if (j > 32'h4000_0000)
            j = 32'h4000_0000;
        return j;
    endfunction

    // Draws the next random sample: mostly runs around a base point, with
    // the odd fully random sample mixed in.
    function automatic tracker_sample_t draw_sample();
        tracker_sample_t s;
        s.meas = $urandom;
        s.dcmd = $urandom;
        if ($urandom_range(0, 99) < 15)
        begin
            s.az     = $urandom;
            s.el     = $urandom;
            s.beat   = $urandom;
            s.locked = 1'($urandom_range(0, 1));
            s.refm   = 1'($urandom_range(0, 1));
            s.img    = 1'($urandom_range(0, 1));
            return s;
        end
        if (run_left == 0)
        begin
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 500)
                                                   : $urandom_range(4, 60);
            if ($urandom_range(0, 7) == 0)
            begin
                // Near the ends of the angle range, where sums wrap.
                base_az = ($urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_0000)
                          + 32'($urandom_range(0, 32'hFFFF));
                base_el = ($urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_0000)
                          + 32'($urandom_range(0, 32'hFFFF));
            end
            else
            begin
                base_az = $urandom;
                base_el = $urandom;
            end
            jit_az = pick_jitter(thr_az);
            jit_el = pick_jitter(thr_el);
        end
        run_left--;
        if ($urandom_range(0, 99) < 8)
            beat_now = $urandom_range(0, 1) ? beat_now + 1 : $urandom;
        s.az     = wobble(base_az, jit_az);
        s.el     = wobble(base_el, jit_el);
        s.beat   = beat_now;
        s.locked = ($urandom_range(0, 99) < 8);
        s.refm   = ($urandom_range(0, 99) < 2);
        s.img    = ($urandom_range(0, 99) < 25);
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Directed plan. Rows with a typed-in result cover the state straight
    // after reset, the distance hold rules, the extremes of the angles, the
    // image history with wrapping slopes, and reference mode leaving the
    // distance and heartbeat alone. The remaining rows probe the threshold
    // edges and lock against heartbeat precedence, checked by the shadow.
    // ------------------------------------------------------------------------
    plan_row_t plan [16];

    initial
    begin
        tracker_report_t none;
        int              k;
        int              p;

        none = '0;
        //                az            el            meas          dcmd
        //                beat    lk    rm    im      lit   count     still hold
        //                image_az      image_el      az_slope      el_slope
        // First sample after reset: heartbeat unchanged, stable against itself.
        plan[0]  = '{'{32'h0, 32'h0, 32'h5, 32'h7, 32'h0, 1'b0, 1'b0, 1'b0},
                     1'b1, '{16'd1, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}};
        // Locked takes the measured distance; the counter restarts at one.
        plan[1]  = '{'{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0},
                     1'b1, '{16'd1, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0}};
        // A heartbeat change while unlocked takes the commanded distance.
        plan[2]  = '{'{32'h0, 32'h0, 32'h0, 32'h1234_5678, 32'h1, 1'b0, 1'b0, 1'b0},
                     1'b1, '{16'd2, 1'b0, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0}};
        // Opposite angle extremes in the window: no wrap, so not stable.
        plan[3]  = '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h1,
                       1'b0, 1'b0, 1'b1},
                     1'b1, '{16'd0, 1'b0, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0}};
        // Image flag in reference mode still moves the history.
        plan[4]  = '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1,
                       1'b0, 1'b1, 1'b1},
                     1'b1, '{16'd0, 1'b0, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000}};
        // Slopes between the two extremes wrap round.
        plan[5]  = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 1'b0, 1'b1, 1'b1},
                     1'b1, '{16'd0, 1'b0, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h0000_0001, 32'hFFFF_FFFF}};
        // Reference mode ignores lock and a heartbeat change.
        plan[6]  = '{'{32'h0, 32'h0, 32'hAAAA_5555, 32'h0, 32'h1, 1'b1, 1'b1, 1'b0},
                     1'b1, '{16'd0, 1'b0, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h0000_0001, 32'hFFFF_FFFF}};
        plan[7]  = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h5, 1'b0, 1'b1, 1'b0},
                     1'b1, '{16'd0, 1'b0, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h0000_0001, 32'hFFFF_FFFF}};
        // Threshold edges: exactly the default threshold is still stable.
        plan[8]  = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 1'b0, 1'b0, 1'b0}, 1'b0, none};
        plan[9]  = '{'{32'd655, -32'sd655, 32'h0, 32'h0, 32'h1, 1'b0, 1'b0, 1'b0},
                     1'b0, none};
        plan[10] = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 1'b0, 1'b0, 1'b0}, 1'b0, none};
        plan[11] = '{'{32'd656, 32'h0, 32'h0, 32'h0, 32'h1, 1'b0, 1'b0, 1'b0}, 1'b0, none};
        // Lock wins over a heartbeat change, which is then seen afterwards.
        plan[12] = '{'{32'd656, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h9, 1'b1, 1'b0, 1'b0},
                     1'b0, none};
        plan[13] = '{'{32'd656, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h9, 1'b0, 1'b0, 1'b0},
                     1'b0, none};
        plan[14] = '{'{32'd656, 32'h0, 32'h0, 32'h0, 32'h9, 1'b0, 1'b0, 1'b0}, 1'b0, none};
        plan[15] = '{'{32'h100, 32'h0, 32'h0001_0000, 32'h0, 32'h9, 1'b1, 1'b0, 1'b1},
                     1'b0, none};

        clear_tracker();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        for (k = 0; k < 16; k++)
            offer_sample(plan[k].smp, plan[k].has_lit, plan[k].lit);

        beat_now = 32'h9;

        // Random phases, each under its own register settings.
        for (p = 0; p < 5; p++)
        begin
            drain_reports();
            case (p)
                0:
                begin
                    write_reg(CFG_AZ_THR, 31'd655);
                    write_reg(CFG_EL_THR, 31'd655);
                    write_reg(CFG_STILL_LIMIT, 31'd3);
                end
                1:
                begin
                    write_reg(CFG_AZ_THR, '0);
                    write_reg(CFG_EL_THR, '0);
                    write_reg(CFG_STILL_LIMIT, '0);
                end
                2:
                begin
                    write_reg(CFG_AZ_THR, 31'h7FFF_FFFF);
                    write_reg(CFG_EL_THR, 31'h7FFF_FFFF);
                    write_reg(CFG_STILL_LIMIT, 31'(16'hFFFF));
                end
                3:
                begin
                    write_reg(CFG_AZ_THR, 31'($urandom_range(0, 32'h10_0000)));
                    write_reg(CFG_EL_THR, 31'($urandom_range(0, 32'h10_0000)));
                    write_reg(CFG_STILL_LIMIT, 31'($urandom_range(0, 20)));
                end
                default:
                begin
                    write_reg(CFG_AZ_THR, 31'($urandom));
                    write_reg(CFG_EL_THR, 31'($urandom));
                    write_reg(CFG_STILL_LIMIT, 31'($urandom_range(0, 40)));
                end
            endcase
            run_left = 0;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % 64 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // Once mid-phase, hold the sender until the block has
                // delivered everything it owes.
                if (p == 2 && k == PHASE_ITEMS / 2)
                    drain_reports();
                offer_sample(draw_sample(), 1'b0, none);
            end
            calm = 1'b0;
        end

        drain_reports();
        repeat (4) @(negedge clk);

        $display("covered %0d samples (%0d with image flag, %0d in reference mode), %0d results",
                 n_samples, n_images, n_refmode, n_results);
        $display("peak stable count %0d, still in %0d results, saturated in %0d, %0d mismatches",
                 peak_count, n_still, n_saturated, mismatches);
        if (mismatches == 0 && due_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/gsd_pkg.sv
rtl/core/gsd_cell.sv
rtl/core/gsd_window.sv
rtl/core/gimbal_stillness_detector.sv
sim/tb_gimbal_stillness_detector.sv
